@@ rtl/core/chbd_pkg.sv @@
package chbd_pkg;

  localparam int BYTE_W    = 8;
  localparam int SYM_COUNT = 257;
  localparam int SYM_W     = 9;
  localparam int MAX_LEN   = 32;
  localparam int LEN_W     = 6;
  localparam int LIDX_W    = 5;
  localparam int FC_W      = 42;
  localparam int CODE_W    = 32;

  typedef enum logic [1:0] {
    EV_BYTE       = 2'd0,
    EV_BLOCK_END  = 2'd1,
    EV_STREAM_END = 2'd2,
    EV_LEN_ERR    = 2'd3
  } event_t;

endpackage

@@ rtl/core/chbd_front.sv @@
module chbd_front
  import chbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              q_valid,
  output logic [BYTE_W-1:0] q_byte,
  input  logic              q_pop
);

  logic [BYTE_W-1:0] slot [2];
  logic              wp;
  logic              rp;
  logic [1:0]        fill;
  logic              push;

  assign byte_stall = (fill == 2'd2);
  assign push       = byte_valid && !byte_stall;
  assign q_valid    = (fill != 2'd0);
  assign q_byte     = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (q_pop) begin
        rp <= !rp;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ rtl/core/chbd_back.sv @@
module chbd_back
  import chbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [BYTE_W-1:0] q_byte,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [1:0]        event_res,
  output logic [7:0]        symbol,
  output logic              last
);

  typedef enum logic [2:0] {
    S_FETCH, S_BIT, S_LOOKUP, S_FLUSH, S_RANK, S_SORT
  } state_t;

  typedef enum logic [1:0] {PH_HDR, PH_DEC, PH_HALT} phase_t;

  state_t            state;
  phase_t            phase;
  logic [BYTE_W-1:0] cur;
  logic [3:0]        bits_left;
  logic [SYM_W-1:0]  hidx;
  logic [7:0]        fa;
  logic [3:0]        fbt;
  logic              esc;
  logic [SYM_W-1:0]  count [MAX_LEN];
  logic [FC_W-1:0]   fcode [MAX_LEN];
  logic [SYM_W-1:0]  rank  [MAX_LEN];
  logic [SYM_W-1:0]  npos  [MAX_LEN];
  logic [CODE_W-1:0] ca;
  logic [LEN_W-1:0]  cl;
  logic [SYM_W-1:0]  bidx;
  logic [FC_W-1:0]   code_b;
  logic [SYM_W-1:0]  rank_b;
  logic              rd_v;
  logic [SYM_W-1:0]  s_d;

  logic [LEN_W-1:0]  length_table [SYM_COUNT];
  logic [SYM_W-1:0]  sorted_symbols [SYM_COUNT];
  logic [LEN_W-1:0]  lt_q;
  logic [SYM_W-1:0]  sorted_q;

  logic              hold_v;
  event_t            hold_ev;
  logic [7:0]        hold_sym;
  logic              o_v;
  event_t            o_ev;
  logic [7:0]        o_sym;
  logic              o_last;

  logic              bit_in;
  logic              can_push;
  logic              step;
  logic [7:0]        fa_n;
  logic [3:0]        fbt_n;
  logic              h_have;
  logic              h_eos;
  logic              h_esc;
  logic [SYM_W-1:0]  h_len;
  logic [SYM_W-1:0]  h_len_m1;
  logic [LIDX_W-1:0] h_lidx;
  logic              h_bad;
  logic              lt_we;
  logic [CODE_W-1:0] ca_n;
  logic [LEN_W-1:0]  cl_n;
  logic [LIDX_W-1:0] d_idx;
  logic [FC_W-1:0]   d_diff;
  logic              d_match;
  logic [SYM_W-1:0]  d_addr;
  logic              d_end;
  logic [LEN_W-1:0]  lt_m1;
  logic [LIDX_W-1:0] lt_idx;
  logic              so_we;
  logic              so_re;
  logic              lt_re;

  assign bit_in   = cur[BYTE_W-1];
  assign can_push = !o_v || !res_stall;
  assign step     = (state == S_BIT) && (bits_left != 4'd0) && !(hold_v && !can_push);
  assign q_pop    = (state == S_FETCH) && q_valid;

  always_comb begin
    fa_n   = {fa[6:0], bit_in};
    fbt_n  = fbt + 4'd1;
    h_have = 1'b0;
    h_eos  = 1'b0;
    h_esc  = 1'b0;
    h_len  = '0;
    if (!esc) begin
      if (fbt_n == 4'd5) begin
        if (fa_n == 8'd0) begin
          h_esc = 1'b1;
        end else begin
          h_have = 1'b1;
          h_len  = {1'b0, fa_n};
        end
      end
    end else if (fbt_n == 4'd8) begin
      if (fa_n == 8'd0) begin
        h_eos = 1'b1;
      end else begin
        h_have = 1'b1;
        h_len  = {1'b0, fa_n} + 9'd31;
      end
    end
    h_bad    = h_len > SYM_W'(MAX_LEN);
    h_len_m1 = h_len - 9'd1;
    h_lidx   = h_len_m1[LIDX_W-1:0];
  end

  always_comb begin
    ca_n    = {ca[CODE_W-2:0], bit_in};
    cl_n    = cl + 6'd1;
    d_idx   = cl[LIDX_W-1:0];
    d_diff  = FC_W'(ca_n) - fcode[d_idx];
    d_match = (count[d_idx] != '0) && (FC_W'(ca_n) >= fcode[d_idx]) &&
              (d_diff[FC_W-1:SYM_W] == '0) && (d_diff[SYM_W-1:0] < count[d_idx]);
    d_addr  = rank[d_idx] + d_diff[SYM_W-1:0];
    d_end   = (cl_n == LEN_W'(MAX_LEN));
  end

  assign lt_m1  = lt_q - 6'd1;
  assign lt_idx = lt_m1[LIDX_W-1:0];
  assign lt_we  = step && (phase == PH_HDR) && h_have && !h_bad;
  assign so_we  = (state == S_SORT) && rd_v;
  assign so_re  = step && (phase == PH_DEC) && d_match;
  assign lt_re  = (state == S_SORT) && (bidx < SYM_W'(SYM_COUNT));

  always_ff @(posedge clk) begin
    if (lt_we) begin
      length_table[hidx] <= h_len[LEN_W-1:0];
    end
    if (lt_re) begin
      lt_q <= length_table[bidx];
    end
  end

  always_ff @(posedge clk) begin
    if (so_we) begin
      sorted_symbols[npos[lt_idx]] <= s_d;
    end
    if (so_re) begin
      sorted_q <= sorted_symbols[d_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_FETCH;
      phase  <= PH_HDR;
      hidx   <= '0;
      fa     <= '0;
      fbt    <= '0;
      esc    <= 1'b0;
      ca     <= '0;
      cl     <= '0;
      rd_v   <= 1'b0;
      hold_v <= 1'b0;
      o_v    <= 1'b0;
      for (int i = 0; i < MAX_LEN; i++) begin
        count[i] <= '0;
      end
    end else begin
      if (o_v && !res_stall) begin
        o_v <= 1'b0;
      end
      unique case (state)
        S_FETCH: begin
          if (q_valid && (phase != PH_HALT)) begin
            cur       <= q_byte;
            bits_left <= 4'd8;
            state     <= S_BIT;
          end
        end
        S_BIT: begin
          if (bits_left == 4'd0) begin
            state <= S_FLUSH;
          end else if (step) begin
            cur       <= {cur[BYTE_W-2:0], 1'b0};
            bits_left <= bits_left - 4'd1;
            if (phase == PH_HDR) begin
              fa  <= fa_n;
              fbt <= fbt_n;
              if (h_esc) begin
                esc <= 1'b1;
                fbt <= '0;
              end else if (h_eos || (h_have && h_bad)) begin
                phase <= PH_HALT;
                state <= S_FLUSH;
                if (hold_v) begin
                  o_v    <= 1'b1;
                  o_ev   <= hold_ev;
                  o_sym  <= hold_sym;
                  o_last <= 1'b0;
                end
                hold_v   <= 1'b1;
                hold_ev  <= h_eos ? EV_STREAM_END : EV_LEN_ERR;
                hold_sym <= '0;
              end else if (h_have) begin
                fa            <= '0;
                fbt           <= '0;
                esc           <= 1'b0;
                count[h_lidx] <= count[h_lidx] + 9'd1;
                hidx          <= hidx + 9'd1;
                if (hidx == SYM_W'(SYM_COUNT - 1)) begin
                  state  <= S_RANK;
                  bidx   <= '0;
                  code_b <= '0;
                  rank_b <= '0;
                end
              end
            end else begin
              ca <= ca_n;
              cl <= cl_n;
              if (d_match) begin
                ca    <= '0;
                cl    <= '0;
                state <= S_LOOKUP;
              end else if (d_end) begin
                phase <= PH_HALT;
                state <= S_FLUSH;
                if (hold_v) begin
                  o_v    <= 1'b1;
                  o_ev   <= hold_ev;
                  o_sym  <= hold_sym;
                  o_last <= 1'b0;
                end
                hold_v   <= 1'b1;
                hold_ev  <= EV_LEN_ERR;
                hold_sym <= '0;
              end
            end
          end
        end
        S_LOOKUP: begin
          if (!(hold_v && !can_push)) begin
            if (hold_v) begin
              o_v    <= 1'b1;
              o_ev   <= hold_ev;
              o_sym  <= hold_sym;
              o_last <= 1'b0;
            end
            hold_v <= 1'b1;
            state  <= S_BIT;
            if (sorted_q == SYM_W'(SYM_COUNT - 1)) begin
              hold_ev  <= EV_BLOCK_END;
              hold_sym <= '0;
              phase    <= PH_HDR;
              hidx     <= '0;
              fa       <= '0;
              fbt      <= '0;
              esc      <= 1'b0;
              for (int i = 0; i < MAX_LEN; i++) begin
                count[i] <= '0;
              end
            end else begin
              hold_ev  <= EV_BYTE;
              hold_sym <= sorted_q[7:0];
            end
          end
        end
        S_FLUSH: begin
          if (!hold_v) begin
            state <= S_FETCH;
          end else if (can_push) begin
            o_v    <= 1'b1;
            o_ev   <= hold_ev;
            o_sym  <= hold_sym;
            o_last <= 1'b1;
            hold_v <= 1'b0;
            state  <= S_FETCH;
          end
        end
        S_RANK: begin
          fcode[bidx[LIDX_W-1:0]] <= code_b;
          rank[bidx[LIDX_W-1:0]]  <= rank_b;
          npos[bidx[LIDX_W-1:0]]  <= rank_b;
          code_b <= (code_b + FC_W'(count[bidx[LIDX_W-1:0]])) << 1;
          rank_b <= rank_b + count[bidx[LIDX_W-1:0]];
          bidx   <= bidx + 9'd1;
          if (bidx == SYM_W'(MAX_LEN - 1)) begin
            state <= S_SORT;
            bidx  <= '0;
            rd_v  <= 1'b0;
          end
        end
        S_SORT: begin
          if (rd_v) begin
            npos[lt_idx] <= npos[lt_idx] + 9'd1;
          end
          if (lt_re) begin
            rd_v <= 1'b1;
            s_d  <= bidx;
            bidx <= bidx + 9'd1;
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              state <= S_BIT;
              phase <= PH_DEC;
              ca    <= '0;
              cl    <= '0;
            end
          end
        end
        default: state <= S_FETCH;
      endcase
    end
  end

  assign res_valid = o_v;
  assign event_res = o_ev;
  assign symbol    = o_sym;
  assign last      = o_last;

endmodule

@@ rtl/core/canonical_huffman_block_decoder_core.sv @@
// channel  | handshake               | word
// input    | byte_valid / byte_stall | in_byte
// output   | res_valid / res_stall   | event_res, symbol, last
// per byte: fetch, shift each bit, close via flush; each decoded symbol adds a lookup
// table build after each header: code starts per code length, then the symbol sort
// reset: rst synchronous, active high; clears queue, state and code length counts
// a two word queue lets bytes arrive while the decoder stalls on a full result register
module canonical_huffman_block_decoder_core
  import chbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [1:0]        event_res,
  output logic [7:0]        symbol,
  output logic              last
);

  logic              q_valid;
  logic [BYTE_W-1:0] q_byte;
  logic              q_pop;

  chbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .in_byte    (in_byte),
    .q_valid    (q_valid),
    .q_byte     (q_byte),
    .q_pop      (q_pop)
  );

  chbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_byte    (q_byte),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .event_res (event_res),
    .symbol    (symbol),
    .last      (last)
  );

endmodule
